[hdl/hti_pkg.sv]
// Package for the hostname trie block: alphabet constants, payload types and
// the byte-to-symbol map. No dependencies.
package hti_pkg;

    localparam int ALPHA_SIZE = 38;
    localparam int SYM_W      = 6;
    localparam int CNT_OUT_W  = 11;

    localparam logic [SYM_W-1:0] SYM_LETTER_BASE = 6'd10;
    localparam logic [SYM_W-1:0] SYM_DASH        = 6'd36;
    localparam logic [SYM_W-1:0] SYM_DOT         = 6'd37;

    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CASE_SHIFT = 8'h20;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_FIND   = 1'b1;

    typedef struct packed {
        logic             ok;
        logic [SYM_W-1:0] code;
    } t_sym;

    // Lower the byte, then map to 0..37; ok is low for a skipped byte.
    function automatic t_sym sym_of(input logic [7:0] raw);
        logic [7:0] b;
        t_sym       s;
        b = raw;
        s = '{ok: 1'b0, code: '0};
        if (b >= CHAR_UP_A && b <= CHAR_UP_Z) begin
            b = b + CASE_SHIFT;
        end
        if (b >= CHAR_0 && b <= CHAR_9) begin
            s = '{ok: 1'b1, code: SYM_W'(b - CHAR_0)};
        end else if (b >= CHAR_LO_A && b <= CHAR_LO_Z) begin
            s = '{ok: 1'b1, code: SYM_W'(b - CHAR_LO_A) + SYM_LETTER_BASE};
        end else if (b == CHAR_DASH) begin
            s = '{ok: 1'b1, code: SYM_DASH};
        end else if (b == CHAR_DOT) begin
            s = '{ok: 1'b1, code: SYM_DOT};
        end
        return s;
    endfunction

endpackage

[hdl/hti_if.sv]
// Valid/ready channel interfaces for the hostname trie block: one for the
// character words in, one for the result words out. Depends on hti_pkg.
interface hti_in_if
    import hti_pkg::*;
();
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] character;
    logic       final_char;

    modport source (output valid, output action, output character, output final_char,
                    input ready);
    modport sink   (input valid, input action, input character, input final_char,
                    output ready);
endinterface

interface hti_out_if
    import hti_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 matched;
    logic                 status;
    logic [CNT_OUT_W-1:0] nodes_in_use;

    modport source (output valid, output matched, output status, output nodes_in_use,
                    input ready);
    modport sink   (input valid, input matched, input status, input nodes_in_use,
                    output ready);
endinterface

[hdl/hostname_trie_insert_lookup_top.sv]
// Hostname trie, insert and exact lookup, one character word at a time.
// Depends on hti_pkg and the channel interfaces in hti_if.sv.
//
// Each word on i_in carries one raw byte of a hostname, an action (insert or
// find) and a last-byte mark. The byte is lowered and mapped to a 38-symbol
// alphabet (digits, letters, '-', '.'); other bytes are skipped. Insert walks
// the trie and allocates nodes from a counter as children are missing; find
// stops at the first missing child. The last byte of a hostname produces one
// word on o_out (matched, status, nodes_in_use) and sends the walk back to the
// root. Sequence: after reset the block sweeps the child memory to zero, one
// entry per cycle, with i_in.ready low. Afterwards every byte is accepted in
// S_IDLE, which starts the read of the child memory on which the next step
// depends, and is evaluated in S_EVAL; a last byte also starts the read of the
// end-mark memory there and goes on to S_FIN, which waits for o_out to drain.
// The result word sits in an output register, so the next hostname may start
// while the previous result is still waiting to be taken.
module hostname_trie_insert_lookup_top
    import hti_pkg::*;
#(
    parameter int NODE_COUNT = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hti_in_if.sink     i_in,
    hti_out_if.source  o_out
);

    localparam int NODE_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int CNT_W  = NODE_W + 1;
    localparam int DEPTH  = NODE_COUNT * ALPHA_SIZE;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EVAL  = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    // Storage: child pointers per (node, symbol) and end marks per node.
    logic [NODE_W-1:0] child_mem [DEPTH];
    logic              end_mem   [NODE_COUNT];

    t_state             r_state,     n_state;
    logic [ADDR_W-1:0]  r_clr_addr;
    logic [NODE_W-1:0]  r_walk_node, n_walk_node;
    logic               r_failed,    n_failed;
    logic [CNT_W-1:0]   r_next_free, n_next_free;

    // Latched item fields.
    logic               r_find;
    logic               r_last;
    logic               r_sym_ok;
    logic [ADDR_W-1:0]  r_slot;

    // Memory read data.
    logic [NODE_W-1:0]  r_rd_child;
    logic               r_rd_end;

    // Output register.
    logic                 r_out_valid;
    logic                 r_out_matched;
    logic                 r_out_status;
    logic [CNT_OUT_W-1:0] r_out_nodes;

    t_sym               in_sym;
    logic [ADDR_W-1:0]  in_slot;
    logic               in_accept;
    logic               can_push;
    logic               clr_done;

    logic               child_we;
    logic [ADDR_W-1:0]  child_waddr;
    logic [NODE_W-1:0]  child_wdata;
    logic               end_we;
    logic [NODE_W-1:0]  end_waddr;
    logic               end_wdata;
    logic               end_re;
    logic               fin_push;
    logic [31:0]        next_free_wide;

    assign in_sym    = sym_of(i_in.character);
    assign in_slot   = ADDR_W'(r_walk_node) * ADDR_W'(ALPHA_SIZE) + ADDR_W'(in_sym.code);
    assign i_in.ready = (r_state == S_IDLE);
    assign in_accept = i_in.valid && i_in.ready;
    assign can_push  = !r_out_valid || o_out.ready;
    assign clr_done  = (r_clr_addr == ADDR_W'(DEPTH - 1));
    assign fin_push  = (r_state == S_FIN) && can_push;
    assign next_free_wide = 32'(r_next_free);

    // Walk step and sequencing.
    always_comb begin
        n_state     = r_state;
        n_walk_node = r_walk_node;
        n_failed    = r_failed;
        n_next_free = r_next_free;
        child_we    = 1'b0;
        child_waddr = r_slot;
        child_wdata = r_next_free[NODE_W-1:0];
        end_re      = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                child_we    = 1'b1;
                child_waddr = r_clr_addr;
                child_wdata = '0;
                if (clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_sym_ok && !r_failed) begin
                    priority if (r_rd_child != '0) begin
                        n_walk_node = r_rd_child;
                    end else if (r_find) begin
                        n_failed = 1'b1;
                    end else if (r_next_free >= CNT_W'(NODE_COUNT)) begin
                        n_failed = 1'b1;
                    end else begin
                        // Allocate: link the fresh node and advance the pool.
                        child_we    = 1'b1;
                        n_walk_node = r_next_free[NODE_W-1:0];
                        n_next_free = r_next_free + CNT_W'(1);
                    end
                end
                if (r_last) begin
                    end_re  = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FIN: begin
                if (can_push) begin
                    n_walk_node = '0;
                    n_failed    = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // End-mark writes: zero during the sweep, set on a clean insert end.
    always_comb begin
        end_we    = 1'b0;
        end_waddr = r_walk_node;
        end_wdata = 1'b1;
        if (r_state == S_CLEAR) begin
            end_we    = 1'b1;
            end_waddr = r_clr_addr[NODE_W-1:0];
            end_wdata = 1'b0;
        end else if (fin_push && !r_find && !r_failed) begin
            end_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (child_we) begin
            child_mem[child_waddr] <= child_wdata;
        end
        if (in_accept) begin
            r_rd_child <= child_mem[in_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (end_we) begin
            end_mem[end_waddr] <= end_wdata;
        end
        if (end_re) begin
            r_rd_end <= end_mem[n_walk_node];
        end
    end

    // Item latch.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_find   <= (i_in.action == ACT_FIND);
            r_last   <= i_in.final_char;
            r_sym_ok <= in_sym.ok;
            r_slot   <= in_slot;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_walk_node <= '0;
            r_failed    <= 1'b0;
            r_next_free <= CNT_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_walk_node <= n_walk_node;
            r_failed    <= n_failed;
            r_next_free <= n_next_free;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (fin_push) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; hold while the word waits.
    always_ff @(posedge i_clk) begin
        if (fin_push) begin
            r_out_matched <= r_find && !r_failed && r_rd_end;
            r_out_status  <= !r_find && r_failed;
            r_out_nodes   <= next_free_wide[CNT_OUT_W-1:0];
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.matched      = r_out_matched;
    assign o_out.status       = r_out_status;
    assign o_out.nodes_in_use = r_out_nodes;

    // The walk only ever stands on an allocated node.
    a_walk_allocated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_walk_node < r_next_free)
        else $error("walk node beyond allocated pool");

    // The pool never grows past its size.
    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free <= CNT_W'(NODE_COUNT))
        else $error("node pool overrun");

    // A result word appears only out of the final step.
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN))
        else $error("result without final step");

    // An accepted word is evaluated in the next cycle.
    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_EVAL))
        else $error("accepted word not evaluated");

    // The pool only grows by one, and only during evaluation.
    a_alloc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_free != $past(r_next_free)) |->
            ($past(r_state == S_EVAL) && r_next_free == $past(r_next_free) + CNT_W'(1)))
        else $error("unexpected pool change");

endmodule

[verif/tb_top.sv]
// Self-checking testbench for hostname_trie_insert_lookup_top: directed table, then random
// hostnames checked against a behavioral trie held in the bench.
// Depends on hti_pkg, hti_in_if / hti_out_if and the block itself.
module tb_top;
    import hti_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODE_COUNT    = 1024;
    localparam int RANDOM_ITEMS  = 1150;
    localparam int IDLE_LIMIT    = 200000;  // covers the child-memory sweep after reset
    localparam int DRAIN_CYCLES  = 20;
    localparam int NAME_SLOTS    = 64;
    localparam int NAME_MAX      = 16;
    localparam int NO_SYMBOL     = -1;
    localparam int DIR_ROWS      = 24;

    typedef struct packed {
        logic                 matched;
        logic                 status;
        logic [CNT_OUT_W-1:0] nodes_in_use;
    } t_trie_result;

    // One row of the directed table; want is only used where typed is set.
    typedef struct packed {
        logic         act;
        logic [7:0]   ch;
        logic         fin;
        logic         typed;
        t_trie_result want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    hti_in_if  in_ch();
    hti_out_if out_ch();

    hostname_trie_insert_lookup_top #(
        .NODE_COUNT (NODE_COUNT)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Behavioral trie: child links, end marks, allocation counter and the
    // walk of the hostname currently being received.
    // ------------------------------------------------------------------
    logic [9:0]   trie_child [0:NODE_COUNT*ALPHA_SIZE-1];
    bit           trie_end   [0:NODE_COUNT-1];
    int unsigned  trie_free;
    int unsigned  walk_at;
    bit           walk_broken;

    t_trie_result pending_results[$];
    int           mismatch_count;
    int           words_sent;
    int           idle_cycles;
    int           stall_left;
    logic         quiet_run;

    // Stored hostnames, reused later for lookups and re-inserts.
    logic [7:0]   name_store [0:NAME_SLOTS-1][0:NAME_MAX-1];
    int           name_len   [0:NAME_SLOTS-1];
    int           name_cnt;

    // The hostname about to be sent: one byte and one action per word.
    logic [7:0]   host_chars[$];
    logic         host_acts[$];

    t_dir_row     dir_table [0:DIR_ROWS-1];

    // Fold upper case into lower case, then map to 0..37; NO_SYMBOL for a skipped byte.
    function automatic int symbol_index(input logic [7:0] c);
        logic [7:0] lc;
        lc = c;
        if (c >= CHAR_UP_A && c <= CHAR_UP_Z) lc = c | CASE_SHIFT;
        if (lc >= CHAR_0 && lc <= CHAR_9) return int'(lc - CHAR_0);
        if (lc >= CHAR_LO_A && lc <= CHAR_LO_Z) return int'(lc - CHAR_LO_A) + int'(SYM_LETTER_BASE);
        if (lc == CHAR_DASH) return int'(SYM_DASH);
        if (lc == CHAR_DOT) return int'(SYM_DOT);
        return NO_SYMBOL;
    endfunction

    task automatic trie_clear();
        foreach (trie_child[k]) trie_child[k] = '0;
        foreach (trie_end[k]) trie_end[k] = 1'b0;
        trie_free   = 1;
        walk_at     = 0;
        walk_broken = 1'b0;
    endtask

    // Advance the walk by one word; return 1 with the result word on a last byte.
    function automatic bit trie_walk_step(input logic act, input logic [7:0] ch,
                                          input logic fin, output t_trie_result res);
        int          sym;
        int unsigned slot;
        sym = symbol_index(ch);
        res = '0;
        if (sym != NO_SYMBOL && !walk_broken) begin
            slot = walk_at * ALPHA_SIZE + sym;
            if (trie_child[slot] != '0) begin
                walk_at = trie_child[slot];
            end else if (act == ACT_FIND) begin
                walk_broken = 1'b1;
            end else if (trie_free >= NODE_COUNT) begin
                // pool dry: keep what was built, no end mark for this hostname
                walk_broken = 1'b1;
            end else begin
                trie_child[slot]    = trie_free[9:0];
                trie_end[trie_free] = 1'b0;
                walk_at             = trie_free;
                trie_free++;
            end
        end
        if (!fin) return 1'b0;
        res.matched      = (act == ACT_FIND) && !walk_broken && trie_end[walk_at];
        res.status       = (act == ACT_INSERT) && walk_broken;
        res.nodes_in_use = trie_free[CNT_OUT_W-1:0];
        if (act == ACT_INSERT && !walk_broken) trie_end[walk_at] = 1'b1;
        walk_at     = 0;
        walk_broken = 1'b0;
        return 1'b1;
    endfunction

    // Random alphabet byte; letters come in either case.
    function automatic logic [7:0] host_char(input int sym);
        logic [7:0] c;
        if (sym < int'(SYM_LETTER_BASE)) return CHAR_0 + 8'(sym);
        if (sym < int'(SYM_DASH)) begin
            c = CHAR_LO_A + 8'(sym - int'(SYM_LETTER_BASE));
            if ($urandom_range(0, 1) == 1) c = c - CASE_SHIFT;
            return c;
        end
        if (sym == int'(SYM_DASH)) return CHAR_DASH;
        return CHAR_DOT;
    endfunction

    // Any byte outside the alphabet, the high half included.
    function automatic logic [7:0] skipped_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (symbol_index(c) != NO_SYMBOL) c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_run) return 0;
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Drive one word, hold it until taken, then predict its result. A typed row
    // overrides the predicted result word; the prediction still advances the trie.
    task automatic send_word(input logic act, input logic [7:0] ch, input logic fin,
                             input logic typed, input t_trie_result want);
        int           gap;
        t_trie_result res;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.action     <= act;
        in_ch.character  <= ch;
        in_ch.final_char <= fin;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        words_sent++;
        if (trie_walk_step(act, ch, fin, res)) begin
            pending_results.push_back(typed ? want : res);
        end
    endtask

    task automatic send_hostname();
        for (int i = 0; i < host_chars.size(); i++) begin
            send_word(host_acts[i], host_chars[i], i == host_chars.size() - 1, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure, compare every word taken against
    // the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_trie_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result word: matched %0d status %0d nodes %0d",
                         $time, out_ch.matched, out_ch.status, out_ch.nodes_in_use);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_ch.matched !== want.matched) begin
                    $display("%0t matched: expected %0d, got %0d",
                             $time, want.matched, out_ch.matched);
                    mismatch_count++;
                end
                if (out_ch.status !== want.status) begin
                    $display("%0t status: expected %0d, got %0d",
                             $time, want.status, out_ch.status);
                    mismatch_count++;
                end
                if (out_ch.nodes_in_use !== want.nodes_in_use) begin
                    $display("%0t nodes_in_use: expected %0d, got %0d",
                             $time, want.nodes_in_use, out_ch.nodes_in_use);
                    mismatch_count++;
                end
            end
        end
        // Hold ready low for a stall, mostly short, now and then long.
        if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end else if (!quiet_run && $urandom_range(0, 99) < 25) begin
            stall_left   = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
                                                        : $urandom_range(9, 39);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Watchdog: drop out if no word moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t timeout: no word moved for %0d cycles", $time, idle_cycles);
            $display("tb_top NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int          kind;
        int          len;
        int          slot;
        logic [7:0]  c;
        logic        act;

        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.action     = ACT_INSERT;
        in_ch.character  = '0;
        in_ch.final_char = 1'b0;
        out_ch.ready     = 1'b0;
        quiet_run        = 1'b0;
        stall_left       = 0;
        idle_cycles      = 0;
        mismatch_count   = 0;
        words_sent       = 0;
        name_cnt         = 0;
        trie_clear();

        // Directed rows. Typed results: empty trie, empty hostname on the root,
        // every alphabet edge in one hostname, case folding, mixed actions.
        dir_table = '{
            // lookup of '.' in an empty trie misses
            '{ACT_FIND,   CHAR_DOT,   1'b1, 1'b1, '{1'b0, 1'b0, 11'd1}},
            // empty hostname: root not marked yet
            '{ACT_FIND,   8'h00,      1'b1, 1'b1, '{1'b0, 1'b0, 11'd1}},
            // empty hostname insert marks the root
            '{ACT_INSERT, 8'hFF,      1'b1, 1'b1, '{1'b0, 1'b0, 11'd1}},
            '{ACT_FIND,   8'h80,      1'b1, 1'b1, '{1'b1, 1'b0, 11'd1}},
            // "09AZaz-." takes eight fresh nodes
            '{ACT_INSERT, CHAR_0,     1'b0, 1'b0, '0},
            '{ACT_INSERT, CHAR_9,     1'b0, 1'b0, '0},
            '{ACT_INSERT, CHAR_UP_A,  1'b0, 1'b0, '0},
            '{ACT_INSERT, CHAR_UP_Z,  1'b0, 1'b0, '0},
            '{ACT_INSERT, CHAR_LO_A,  1'b0, 1'b0, '0},
            '{ACT_INSERT, CHAR_LO_Z,  1'b0, 1'b0, '0},
            '{ACT_INSERT, CHAR_DASH,  1'b0, 1'b0, '0},
            '{ACT_INSERT, CHAR_DOT,   1'b1, 1'b1, '{1'b0, 1'b0, 11'd9}},
            // same hostname, opposite case
            '{ACT_FIND,   CHAR_0,     1'b0, 1'b0, '0},
            '{ACT_FIND,   CHAR_9,     1'b0, 1'b0, '0},
            '{ACT_FIND,   CHAR_LO_A,  1'b0, 1'b0, '0},
            '{ACT_FIND,   CHAR_LO_Z,  1'b0, 1'b0, '0},
            '{ACT_FIND,   CHAR_UP_A,  1'b0, 1'b0, '0},
            '{ACT_FIND,   CHAR_UP_Z,  1'b0, 1'b0, '0},
            '{ACT_FIND,   CHAR_DASH,  1'b0, 1'b0, '0},
            '{ACT_FIND,   CHAR_DOT,   1'b1, 1'b1, '{1'b1, 1'b0, 11'd9}},
            // insert step, then a skipped last byte tested by find: unmarked node
            '{ACT_INSERT, 8'h78,      1'b0, 1'b0, '0},
            '{ACT_FIND,   8'h40,      1'b1, 1'b1, '{1'b0, 1'b0, 11'd10}},
            // find misses, a later insert byte of the same hostname reports failure
            '{ACT_FIND,   8'h71,      1'b0, 1'b0, '0},
            '{ACT_INSERT, 8'h71,      1'b1, 1'b1, '{1'b0, 1'b1, 11'd10}}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The block sweeps its child memory first; send_word simply waits for ready.
        foreach (dir_table[r]) begin
            send_word(dir_table[r].act, dir_table[r].ch, dir_table[r].fin,
                      dir_table[r].typed, dir_table[r].want);
        end

        // Random hostnames: insert-heavy to fill the pool, with lookups of stored
        // names, near misses, re-inserts, random lookups and raw noise.
        while (words_sent < RANDOM_ITEMS) begin
            host_chars.delete();
            host_acts.delete();
            quiet_run <= ($urandom_range(0, 99) < 15);
            kind = $urandom_range(0, 99);
            if (kind < 55 || name_cnt == 0) begin
                len  = $urandom_range(1, 14);
                slot = (name_cnt < NAME_SLOTS) ? name_cnt : $urandom_range(0, NAME_SLOTS - 1);
                if (name_cnt < NAME_SLOTS) name_cnt++;
                for (int i = 0; i < len; i++) begin
                    c = ($urandom_range(0, 99) < 6) ? skipped_byte()
                                                    : host_char($urandom_range(0, 37));
                    host_chars.push_back(c);
                    host_acts.push_back(ACT_INSERT);
                    name_store[slot][i] = c;
                end
                name_len[slot] = len;
            end else if (kind < 87) begin
                // reuse a stored name: plain lookup, near miss, or re-insert
                slot = $urandom_range(0, name_cnt - 1);
                act  = (kind < 82) ? ACT_FIND : ACT_INSERT;
                for (int i = 0; i < name_len[slot]; i++) begin
                    c = name_store[slot][i];
                    if ((c | CASE_SHIFT) >= CHAR_LO_A && (c | CASE_SHIFT) <= CHAR_LO_Z
                            && $urandom_range(0, 1) == 1) begin
                        c = c ^ CASE_SHIFT;
                    end
                    host_chars.push_back(c);
                    host_acts.push_back(act);
                end
                if (kind >= 75) begin
                    if (kind < 82 && host_chars.size() > 1 && $urandom_range(0, 1) == 1) begin
                        void'(host_chars.pop_back());
                        void'(host_acts.pop_back());
                    end else if ($urandom_range(0, 1) == 1) begin
                        host_chars.push_back(host_char($urandom_range(0, 37)));
                        host_acts.push_back(act);
                    end
                end
            end else if (kind < 93) begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++) begin
                    host_chars.push_back(host_char($urandom_range(0, 37)));
                    host_acts.push_back(ACT_FIND);
                end
            end else begin
                // raw bytes, action chosen per byte
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    host_chars.push_back(8'($urandom_range(0, 255)));
                    host_acts.push_back(1'($urandom_range(0, 1)));
                end
            end
            send_hostname();
        end

        in_ch.valid <= 1'b0;
        quiet_run   <= 1'b0;

        // Drain: wait for every expected word, then watch a little longer for strays.
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
